// File: src/pvpe_pkg.sv
`timescale 1ns / 1ps

package pvpe_pkg;

    // field widths
    localparam int COORD_W  = 16;
    localparam int VALUE_W  = 32;
    localparam int ENTRY_W  = 4;
    localparam int WORD_W   = 4;
    localparam int GS_W     = 31;
    localparam int TOL_W    = 16;
    localparam int PCNT_W   = 5;
    localparam int ECNT_W   = 3;
    localparam int CFG_IDX_W = 8;

    // datapath widths
    localparam int OPA_W = 48;
    localparam int ACC_W = 64;
    localparam int VAL_W = 36;
    localparam int X_W   = 25;
    localparam int LO_W  = 49;

    // table layout
    localparam int PLANE_WORDS = 4;
    localparam int ELL_WORDS   = 15;
    localparam int PW_OFFSET   = 3;
    localparam int EW_DIR      = 3;
    localparam int EW_INV      = 12;

    // actions of an input item
    typedef enum logic [1:0] {
        ACT_CLASSIFY  = 2'd0,
        ACT_PLANE     = 2'd1,
        ACT_ELLIPSOID = 2'd2
    } t_action;

    // orientation codes
    localparam logic [1:0] ORIENT_INSIDE  = 2'd0;
    localparam logic [1:0] ORIENT_ON      = 2'd1;
    localparam logic [1:0] ORIENT_OUTSIDE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_CNT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ELL_CNT   = 8'd3;

    // saturation limits
    localparam logic signed [ACC_W-1:0] SAT_TERM = 64'sh2000_0000_0000_0000;
    localparam logic signed [ACC_W-1:0] SAT_PROJ = 64'sh0000_4000_0000_0000;
    localparam logic signed [ACC_W-1:0] SAT_AXIS = 64'sh0000_0000_0100_0000;
    localparam logic signed [VAL_W-1:0] ONE_Q16  = 36'sd65536;

    // operand a source of the product unit
    typedef enum logic [1:0] {
        ASEL_Q,
        ASEL_DV,
        ASEL_T
    } t_asel;

    // operand pair of the wide multiplier
    typedef enum logic [1:0] {
        MSEL_SCALE,
        MSEL_PROD,
        MSEL_SQ
    } t_msel;

    typedef struct packed {
        logic              cap_p;
        logic              wr_pl;
        logic              wr_el;
        logic              rd_pl;
        logic              rd_el;
        logic [WORD_W-1:0] wrd;
        logic [1:0]        k;
        t_asel             asel;
        t_msel             msel;
        logic              mul_hi;
        logic              mul_lo;
        logic              q_set;
        logic              dv_set;
        logic              acc_neg;
        logic              acc_zero;
        logic              acc_add;
        logic              clamp_term;
        logic              t_set;
        logic              x_set;
        logic              val_init;
        logic              val_add;
    } t_cmd;

    typedef struct packed {
        logic pl_out;
        logic pl_on;
        logic el_in;
        logic el_on;
    } t_sts;

    function automatic logic signed [ACC_W-1:0] sat(
        input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] lim
    );
        logic signed [ACC_W-1:0] r;
        r = v;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

// File: src/pvpe_if.sv
`timescale 1ns / 1ps

// input items: classify requests and table writes
interface pvpe_in_if;
    import pvpe_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [COORD_W-1:0]  pz;
    logic [ENTRY_W-1:0]         entry;
    logic [WORD_W-1:0]          word;
    logic signed [VALUE_W-1:0]  value;
    modport source (output valid, action, px, py, pz, entry, word, value, input ready);
    modport sink   (input valid, action, px, py, pz, entry, word, value, output ready);
endinterface

// result items
interface pvpe_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] orientation;
    modport source (output valid, orientation, input ready);
    modport sink   (input valid, orientation, output ready);
endinterface

// register writes
interface pvpe_cfg_if;
    import pvpe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VALUE_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/pvpe_dp.sv
`timescale 1ns / 1ps

module pvpe_dp #(
    parameter int MAX_PLANES     = 16,
    parameter int MAX_ELLIPSOIDS = 4,
    parameter int IW             = 4
) (
    input  logic                               i_clk,
    input  pvpe_pkg::t_cmd                     i_cmd,
    input  logic [IW-1:0]                      i_idx,
    input  logic signed [pvpe_pkg::COORD_W-1:0] i_px,
    input  logic signed [pvpe_pkg::COORD_W-1:0] i_py,
    input  logic signed [pvpe_pkg::COORD_W-1:0] i_pz,
    input  logic [pvpe_pkg::ENTRY_W-1:0]       i_entry,
    input  logic [pvpe_pkg::WORD_W-1:0]        i_word,
    input  logic signed [pvpe_pkg::VALUE_W-1:0] i_value,
    input  logic [pvpe_pkg::GS_W-1:0]          i_grid_step,
    input  logic [pvpe_pkg::TOL_W-1:0]         i_tolerance,
    output pvpe_pkg::t_sts                     o_sts
);
    import pvpe_pkg::*;

    localparam int PDEPTH = MAX_PLANES * PLANE_WORDS;
    localparam int EDEPTH = MAX_ELLIPSOIDS * ELL_WORDS;
    localparam int PA_W   = $clog2(PDEPTH);
    localparam int EA_W   = $clog2(EDEPTH);

    logic signed [VALUE_W-1:0] r_pmem [PDEPTH];
    logic signed [VALUE_W-1:0] r_emem [EDEPTH];
    logic signed [VALUE_W-1:0] r_prd;
    logic signed [VALUE_W-1:0] r_erd;
    logic                      r_from_el;

    logic signed [COORD_W-1:0] r_p  [3];
    logic signed [OPA_W-1:0]   r_q  [3];
    logic signed [OPA_W-1:0]   r_dv [3];
    logic signed [VALUE_W-1:0] r_b;
    logic signed [ACC_W-1:0]   r_ph;
    logic signed [LO_W-1:0]    r_pl;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [OPA_W-1:0]   r_t;
    logic signed [X_W-1:0]     r_x;
    logic signed [VAL_W-1:0]   r_val;

    logic [PA_W-1:0]           pw_addr;
    logic [PA_W-1:0]           pr_addr;
    logic [EA_W-1:0]           ew_addr;
    logic [EA_W-1:0]           er_addr;
    logic                      pw_ok;
    logic                      ew_ok;
    logic signed [VALUE_W-1:0] rdata;
    logic signed [OPA_W-1:0]   opa;
    logic signed [31:0]        m_a;
    logic signed [31:0]        m_b;
    logic signed [ACC_W-1:0]   m_prod;
    logic signed [16:0]        a_lo;
    logic signed [LO_W-1:0]    lo_prod;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   term_c;
    logic signed [ACC_W-1:0]   tol_acc;
    logic signed [VAL_W-1:0]   tol_val;

    // table addressing
    assign pw_addr = PA_W'(int'(i_entry) * PLANE_WORDS + int'(i_word));
    assign ew_addr = EA_W'(int'(i_entry) * ELL_WORDS + int'(i_word));
    assign pr_addr = PA_W'(int'(i_idx) * PLANE_WORDS + int'(i_cmd.wrd));
    assign er_addr = EA_W'(int'(i_idx) * ELL_WORDS + int'(i_cmd.wrd));
    assign pw_ok   = (int'(i_entry) < MAX_PLANES) && (int'(i_word) < PLANE_WORDS);
    assign ew_ok   = (int'(i_entry) < MAX_ELLIPSOIDS) && (int'(i_word) < ELL_WORDS);

    // plane table
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pl && pw_ok) begin
            r_pmem[pw_addr] <= i_value;
        end
        if (i_cmd.rd_pl) begin
            r_prd <= r_pmem[pr_addr];
        end
    end

    // ellipsoid table
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_el && ew_ok) begin
            r_emem[ew_addr] <= i_value;
        end
        if (i_cmd.rd_el) begin
            r_erd <= r_emem[er_addr];
        end
    end

    assign rdata = r_from_el ? r_erd : r_prd;

    // operand a of the q16 product
    always_comb begin
        case (i_cmd.asel)
            ASEL_Q:  opa = r_q[i_cmd.k];
            ASEL_DV: opa = r_dv[i_cmd.k];
            default: opa = r_t;
        endcase
    end

    // shared 32x32 multiplier
    always_comb begin
        case (i_cmd.msel)
            MSEL_SCALE: begin
                m_a = 32'(r_p[i_cmd.k]);
                m_b = $signed({1'b0, i_grid_step});
            end
            MSEL_SQ: begin
                m_a = 32'(r_x);
                m_b = 32'(r_x);
            end
            default: begin
                m_a = opa[OPA_W-1:16];
                m_b = rdata;
            end
        endcase
    end

    assign m_prod  = m_a * m_b;
    assign a_lo    = $signed({1'b0, opa[15:0]});
    assign lo_prod = a_lo * r_b;

    // floor(a*b / 2^16) from the two partial products
    assign term    = r_ph + ACC_W'(r_pl >>> 16);
    assign term_c  = i_cmd.clamp_term ? sat(term, SAT_TERM) : term;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_pl) begin
            r_from_el <= 1'b0;
        end else if (i_cmd.rd_el) begin
            r_from_el <= 1'b1;
        end
        if (i_cmd.cap_p) begin
            r_p[0] <= i_px;
            r_p[1] <= i_py;
            r_p[2] <= i_pz;
        end
        if (i_cmd.mul_hi) begin
            r_ph <= m_prod;
            r_b  <= rdata;
        end
        if (i_cmd.mul_lo) begin
            r_pl <= lo_prod;
        end
        if (i_cmd.q_set) begin
            r_q[i_cmd.k] <= OPA_W'(r_ph);
        end
        if (i_cmd.dv_set) begin
            r_dv[i_cmd.k] <= r_q[i_cmd.k] - OPA_W'(rdata);
        end
        // distance and projection accumulator
        if (i_cmd.acc_neg) begin
            r_acc <= -ACC_W'(rdata);
        end else if (i_cmd.acc_zero) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + term_c;
        end
        if (i_cmd.t_set) begin
            r_t <= OPA_W'(sat(r_acc, SAT_PROJ));
        end
        if (i_cmd.x_set) begin
            r_x <= X_W'(sat(term, SAT_AXIS));
        end
        // quadric value
        if (i_cmd.val_init) begin
            r_val <= -ONE_Q16;
        end else if (i_cmd.val_add) begin
            r_val <= r_val + VAL_W'(r_ph >>> 16);
        end
    end

    // tolerance compares
    assign tol_acc = $signed({{(ACC_W-TOL_W){1'b0}}, i_tolerance});
    assign tol_val = $signed({{(VAL_W-TOL_W){1'b0}}, i_tolerance});

    assign o_sts.pl_out = r_acc > tol_acc;
    assign o_sts.pl_on  = r_acc >= -tol_acc;
    assign o_sts.el_in  = r_val < -tol_val;
    assign o_sts.el_on  = r_val < tol_val;

endmodule

// File: src/pvpe_ctrl.sv
`timescale 1ns / 1ps

module pvpe_ctrl #(
    parameter int MAX_PLANES     = 16,
    parameter int MAX_ELLIPSOIDS = 4,
    parameter int IW             = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [1:0]                  i_action,
    output logic                        o_in_ready,
    input  logic [pvpe_pkg::PCNT_W-1:0] i_plane_count,
    input  logic [pvpe_pkg::ECNT_W-1:0] i_ell_count,
    output pvpe_pkg::t_cmd              o_cmd,
    output logic [IW-1:0]               o_idx,
    input  pvpe_pkg::t_sts              i_sts,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_orientation
);
    import pvpe_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCALE_M,
        S_SCALE_W,
        S_PL_OFF_RD,
        S_PL_OFF,
        S_PL_HI,
        S_PL_LO,
        S_PL_ACC,
        S_PL_CHK,
        S_EL_BEGIN,
        S_EL_C_RD,
        S_EL_C_SUB,
        S_EL_T_START,
        S_EL_T_HI,
        S_EL_T_LO,
        S_EL_T_ACC,
        S_EL_I_RD,
        S_EL_I_HI,
        S_EL_I_LO,
        S_EL_I_X,
        S_EL_SQ,
        S_EL_SQ_ACC,
        S_EL_CHK,
        S_EMIT
    } t_state;

    t_state        r_state;
    logic [IW-1:0] r_i;
    logic [1:0]    r_k;
    logic [1:0]    r_ax;
    logic [1:0]    r_o;
    logic          r_ovalid;
    logic [1:0]    r_orient;

    t_cmd cmd;
    int   np;
    int   ne;
    logic last_pl;
    logic last_el;

    // counts limited to the table sizes
    assign np      = (int'(i_plane_count) > MAX_PLANES) ? MAX_PLANES : int'(i_plane_count);
    assign ne      = (int'(i_ell_count) > MAX_ELLIPSOIDS) ? MAX_ELLIPSOIDS : int'(i_ell_count);
    assign last_pl = (int'(r_i) + 1) >= np;
    assign last_el = (int'(r_i) + 1) >= ne;

    // command decode
    always_comb begin
        cmd      = '0;
        cmd.k    = r_k;
        cmd.asel = ASEL_Q;
        cmd.msel = MSEL_PROD;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_action)
                        ACT_CLASSIFY:  cmd.cap_p = 1'b1;
                        ACT_PLANE:     cmd.wr_pl = 1'b1;
                        ACT_ELLIPSOID: cmd.wr_el = 1'b1;
                        default:       cmd.cap_p = 1'b0;
                    endcase
                end
            end
            S_SCALE_M: begin
                cmd.msel   = MSEL_SCALE;
                cmd.mul_hi = 1'b1;
            end
            S_SCALE_W: cmd.q_set = 1'b1;
            S_PL_OFF_RD: begin
                cmd.rd_pl = 1'b1;
                cmd.wrd   = WORD_W'(PW_OFFSET);
            end
            S_PL_OFF: begin
                cmd.acc_neg = 1'b1;
                cmd.rd_pl   = 1'b1;
                cmd.wrd     = '0;
            end
            S_PL_HI: cmd.mul_hi = 1'b1;
            S_PL_LO: begin
                cmd.mul_lo = 1'b1;
                if (r_k != 2'd2) begin
                    cmd.rd_pl = 1'b1;
                    cmd.wrd   = WORD_W'(int'(r_k) + 1);
                end
            end
            S_PL_ACC: cmd.acc_add = 1'b1;
            S_PL_CHK: cmd.k = r_k;
            S_EL_BEGIN: cmd.k = r_k;
            S_EL_C_RD: begin
                cmd.rd_el = 1'b1;
                cmd.wrd   = WORD_W'(r_k);
            end
            S_EL_C_SUB: begin
                cmd.dv_set   = 1'b1;
                cmd.val_init = 1'b1;
            end
            S_EL_T_START: begin
                cmd.acc_zero = 1'b1;
                cmd.rd_el    = 1'b1;
                cmd.wrd      = WORD_W'(EW_DIR + 3 * int'(r_ax));
            end
            S_EL_T_HI: begin
                cmd.asel   = ASEL_DV;
                cmd.mul_hi = 1'b1;
            end
            S_EL_T_LO: begin
                cmd.asel   = ASEL_DV;
                cmd.mul_lo = 1'b1;
                if (r_k != 2'd2) begin
                    cmd.rd_el = 1'b1;
                    cmd.wrd   = WORD_W'(EW_DIR + 3 * int'(r_ax) + int'(r_k) + 1);
                end
            end
            S_EL_T_ACC: begin
                cmd.acc_add    = 1'b1;
                cmd.clamp_term = 1'b1;
            end
            S_EL_I_RD: begin
                cmd.t_set = 1'b1;
                cmd.rd_el = 1'b1;
                cmd.wrd   = WORD_W'(EW_INV + int'(r_ax));
            end
            S_EL_I_HI: begin
                cmd.asel   = ASEL_T;
                cmd.mul_hi = 1'b1;
            end
            S_EL_I_LO: begin
                cmd.asel   = ASEL_T;
                cmd.mul_lo = 1'b1;
            end
            S_EL_I_X: cmd.x_set = 1'b1;
            S_EL_SQ: begin
                cmd.msel   = MSEL_SQ;
                cmd.mul_hi = 1'b1;
            end
            S_EL_SQ_ACC: cmd.val_add = 1'b1;
            S_EL_CHK: cmd.k = r_k;
            S_EMIT: cmd.k = r_k;
            default: cmd.k = r_k;
        endcase
        cmd.val_init = cmd.val_init && (r_k == 2'd0);
    end

    assign o_cmd         = cmd;
    assign o_idx         = r_i;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_orientation = r_orient;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_k      <= '0;
            r_ax     <= '0;
            r_o      <= ORIENT_INSIDE;
        end else begin
            if (r_ovalid && i_out_ready && r_state != S_EMIT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_action == ACT_CLASSIFY) begin
                        r_k     <= '0;
                        r_state <= S_SCALE_M;
                    end
                end
                S_SCALE_M: r_state <= S_SCALE_W;
                S_SCALE_W: begin
                    if (r_k == 2'd2) begin
                        r_i <= '0;
                        r_k <= '0;
                        if (np == 0) begin
                            r_o     <= ORIENT_OUTSIDE;
                            r_state <= S_EL_BEGIN;
                        end else begin
                            r_o     <= ORIENT_INSIDE;
                            r_state <= S_PL_OFF_RD;
                        end
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_SCALE_M;
                    end
                end
                S_PL_OFF_RD: r_state <= S_PL_OFF;
                S_PL_OFF: begin
                    r_k     <= '0;
                    r_state <= S_PL_HI;
                end
                S_PL_HI: r_state <= S_PL_LO;
                S_PL_LO: r_state <= S_PL_ACC;
                S_PL_ACC: begin
                    if (r_k == 2'd2) begin
                        r_state <= S_PL_CHK;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_PL_HI;
                    end
                end
                // plane verdict: outside ends the plane pass
                S_PL_CHK: begin
                    if (i_sts.pl_out) begin
                        r_o     <= ORIENT_OUTSIDE;
                        r_state <= S_EL_BEGIN;
                    end else begin
                        if (i_sts.pl_on) begin
                            r_o <= ORIENT_ON;
                        end
                        if (last_pl) begin
                            r_state <= S_EL_BEGIN;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_PL_OFF_RD;
                        end
                    end
                end
                S_EL_BEGIN: begin
                    r_i <= '0;
                    r_k <= '0;
                    if (r_o == ORIENT_INSIDE || ne == 0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_EL_C_RD;
                    end
                end
                S_EL_C_RD: r_state <= S_EL_C_SUB;
                S_EL_C_SUB: begin
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_ax    <= '0;
                        r_state <= S_EL_T_START;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_EL_C_RD;
                    end
                end
                S_EL_T_START: r_state <= S_EL_T_HI;
                S_EL_T_HI:    r_state <= S_EL_T_LO;
                S_EL_T_LO:    r_state <= S_EL_T_ACC;
                S_EL_T_ACC: begin
                    if (r_k == 2'd2) begin
                        r_state <= S_EL_I_RD;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_EL_T_HI;
                    end
                end
                S_EL_I_RD: r_state <= S_EL_I_HI;
                S_EL_I_HI: r_state <= S_EL_I_LO;
                S_EL_I_LO: r_state <= S_EL_I_X;
                S_EL_I_X:  r_state <= S_EL_SQ;
                S_EL_SQ:   r_state <= S_EL_SQ_ACC;
                S_EL_SQ_ACC: begin
                    r_k <= '0;
                    if (r_ax == 2'd2) begin
                        r_state <= S_EL_CHK;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_EL_T_START;
                    end
                end
                // ellipsoid verdict: strictly inside wins at once
                S_EL_CHK: begin
                    r_k <= '0;
                    if (i_sts.el_in) begin
                        r_o     <= ORIENT_INSIDE;
                        r_state <= S_EMIT;
                    end else begin
                        if (i_sts.el_on) begin
                            r_o <= ORIENT_ON;
                        end
                        if (last_el) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_EL_C_RD;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid <= 1'b1;
                        r_orient <= r_o;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/point_vs_planes_ellipsoids_classifier.sv
`timescale 1ns / 1ps

// Classifies a lattice point as inside, on or outside a shape made of the
// intersection of plane half-spaces united with ellipsoids.
// i_in carries items: classify a point, or write one Q16.16 word of the
// plane or ellipsoid table. i_cfg writes grid step, tolerance and counts;
// it is always ready; the user must write it only while no item is in
// flight, which the block does not enforce. o_out returns one
// orientation item per classify; writes return nothing. Classify time
// is set by the shared 32x32 multiplier together with a 17x32
// multiplier for the low part, which run every plane and axis product
// as a high and a low partial product that are then summed, and by
// the registered read of each table word.
// One item is worked on at a time; the finished orientation sits in an
// output register, so the next item is taken while it waits. If the
// receiver stalls, the block holds a newer result until the slot frees.
// Reset (synchronous, active low) restores the register defaults and
// empties the output; table contents are kept and are undefined until
// written.
module point_vs_planes_ellipsoids_classifier #(
    parameter int MAX_PLANES     = 16,
    parameter int MAX_ELLIPSOIDS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pvpe_in_if.sink     i_in,
    pvpe_out_if.source  o_out,
    pvpe_cfg_if.sink    i_cfg
);
    import pvpe_pkg::*;

    localparam int MAXN = (MAX_PLANES > MAX_ELLIPSOIDS) ? MAX_PLANES : MAX_ELLIPSOIDS;
    localparam int IW   = (MAXN > 1) ? $clog2(MAXN) : 1;

    logic [GS_W-1:0]   r_grid_step;
    logic [TOL_W-1:0]  r_tolerance;
    logic [PCNT_W-1:0] r_plane_count;
    logic [ECNT_W-1:0] r_ell_count;

    t_cmd          cmd;
    t_sts          sts;
    logic [IW-1:0] idx;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_step   <= GS_W'(65536);
            r_tolerance   <= TOL_W'(1);
            r_plane_count <= '0;
            r_ell_count   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_GRID_STEP: r_grid_step   <= i_cfg.data[GS_W-1:0];
                CFG_TOLERANCE: r_tolerance   <= i_cfg.data[TOL_W-1:0];
                CFG_PLANE_CNT: r_plane_count <= i_cfg.data[PCNT_W-1:0];
                CFG_ELL_CNT:   r_ell_count   <= i_cfg.data[ECNT_W-1:0];
                default:       r_tolerance   <= r_tolerance;
            endcase
        end
    end

    pvpe_ctrl #(
        .MAX_PLANES     (MAX_PLANES),
        .MAX_ELLIPSOIDS (MAX_ELLIPSOIDS),
        .IW             (IW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_action      (i_in.action),
        .o_in_ready    (i_in.ready),
        .i_plane_count (r_plane_count),
        .i_ell_count   (r_ell_count),
        .o_cmd         (cmd),
        .o_idx         (idx),
        .i_sts         (sts),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_orientation (o_out.orientation)
    );

    pvpe_dp #(
        .MAX_PLANES     (MAX_PLANES),
        .MAX_ELLIPSOIDS (MAX_ELLIPSOIDS),
        .IW             (IW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .i_px        (i_in.px),
        .i_py        (i_in.py),
        .i_pz        (i_in.pz),
        .i_entry     (i_in.entry),
        .i_word      (i_in.word),
        .i_value     (i_in.value),
        .i_grid_step (r_grid_step),
        .i_tolerance (r_tolerance),
        .o_sts       (sts)
    );

endmodule

// File: src/pvpe_chk.sv
`timescale 1ns / 1ps

module pvpe_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_action,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_orientation
);
    import pvpe_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_orientation))
        else $error("result changed while stalled");

    // a classify item keeps the block busy the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_action == ACT_CLASSIFY |=> !i_in_ready)
        else $error("new item taken during classify");

    // a new result only appears at the end of a classify
    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while idle");

    // only defined orientation codes leave the block
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_orientation == ORIENT_INSIDE || i_orientation == ORIENT_ON
                         || i_orientation == ORIENT_OUTSIDE))
        else $error("undefined orientation code");

endmodule

bind point_vs_planes_ellipsoids_classifier pvpe_chk u_pvpe_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_action      (i_in.action),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_orientation (o_out.orientation)
);
